>>> design/lvs_pkg.sv
package lvs_pkg;

    // Field widths of one input beat and one result beat.
    localparam int SLOT_W      = 6;
    localparam int TAG_W       = 32;
    localparam int REFS_W      = 8;
    localparam int ENTRIES_DEF = 64;

    // Action codes carried by i_action.
    typedef enum logic [1:0] {
        ACT_TOUCH = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Read address source for the link and flag memories.
    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_HEAD = 2'd1,
        RD_NEXT = 2'd2
    } t_rd_src;

    // Link memory write selection.
    typedef enum logic [2:0] {
        LW_NONE   = 3'd0,
        LW_INIT   = 3'd1,
        LW_UNLINK = 3'd2,
        LW_TAIL   = 3'd3,
        LW_HEAD   = 3'd4
    } t_link_wr;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        t_rd_src  rd_src;
        t_link_wr link_wr;
        logic     flag_init;
        logic     flag_write;
        logic     clr_step;
        logic     alloc_start;
        logic     walk_step;
        logic     alloc_hit;
        logic     alloc_miss;
        logic     touch_head;
        logic     touch_cap;
        logic     emit_plain;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_action action;
        logic    in_range;
        logic    is_head;
        logic    is_tail;
        logic    pinned;
        logic    walk_last;
        logic    clr_last;
    } t_stat;

endpackage

>>> design/lvs_ram.sv
module lvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lvs_ctrl.sv
module lvs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lvs_pkg::t_stat i_stat,
    output lvs_pkg::t_cmd  o_cmd,
    output logic          o_busy
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_T_CAP,
        ST_T_W0,
        ST_T_W1,
        ST_T_W2,
        ST_A_WALK
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                // Build the circular order 0..N-1 and clear the slot flags.
                o_cmd.link_wr   = lvs_pkg::LW_INIT;
                o_cmd.flag_init = 1'b1;
                o_cmd.clr_step  = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_stat.action)
                    lvs_pkg::ACT_TOUCH: begin
                        if (!i_stat.in_range || i_stat.is_tail) begin
                            o_cmd.emit_plain = 1'b1;
                            n_state          = ST_IDLE;
                        end else begin
                            o_cmd.rd_src = lvs_pkg::RD_IDX;
                            n_state      = ST_T_CAP;
                        end
                    end
                    lvs_pkg::ACT_ALLOC: begin
                        o_cmd.rd_src      = lvs_pkg::RD_HEAD;
                        o_cmd.alloc_start = 1'b1;
                        n_state           = ST_A_WALK;
                    end
                    lvs_pkg::ACT_WRITE: begin
                        o_cmd.flag_write = i_stat.in_range;
                        o_cmd.emit_plain = 1'b1;
                        n_state          = ST_IDLE;
                    end
                    lvs_pkg::ACT_NONE: begin
                        o_cmd.emit_plain = 1'b1;
                        n_state          = ST_IDLE;
                    end
                endcase
            end
            ST_T_CAP: begin
                // Touching the head is a plain rotation of the circle.
                if (i_stat.is_head) begin
                    o_cmd.touch_head = 1'b1;
                    o_cmd.emit_plain = 1'b1;
                    n_state          = ST_IDLE;
                end else begin
                    o_cmd.touch_cap = 1'b1;
                    n_state         = ST_T_W0;
                end
            end
            ST_T_W0: begin
                o_cmd.link_wr = lvs_pkg::LW_UNLINK;
                n_state       = ST_T_W1;
            end
            ST_T_W1: begin
                o_cmd.link_wr = lvs_pkg::LW_TAIL;
                n_state       = ST_T_W2;
            end
            ST_T_W2: begin
                o_cmd.link_wr    = lvs_pkg::LW_HEAD;
                o_cmd.emit_plain = 1'b1;
                n_state          = ST_IDLE;
            end
            ST_A_WALK: begin
                // One slot of the circle is examined per cycle.
                if (!i_stat.pinned) begin
                    o_cmd.alloc_hit = 1'b1;
                    n_state         = ST_IDLE;
                end else if (i_stat.walk_last) begin
                    o_cmd.alloc_miss = 1'b1;
                    n_state          = ST_IDLE;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    o_cmd.rd_src    = lvs_pkg::RD_NEXT;
                end
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

>>> design/lvs_datapath.sv
module lvs_datapath #(
    parameter int ENTRIES = lvs_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lvs_pkg::t_cmd              i_cmd,
    output lvs_pkg::t_stat             o_stat,
    input  logic [1:0]                 i_action,
    input  logic [lvs_pkg::SLOT_W-1:0] i_slot_index,
    input  logic                       i_tag_valid,
    input  logic [lvs_pkg::REFS_W-1:0] i_ref_count,
    output logic                       o_valid,
    output logic                       o_found,
    output logic [lvs_pkg::SLOT_W-1:0] o_victim_slot,
    output logic                       o_unstable_error
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int PAD_W = IDX_W + lvs_pkg::SLOT_W;

    // Order state: the list is kept circular, so next of the tail is the head.
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] r_tail;
    logic [CNT_W-1:0] r_unused;
    logic [IDX_W-1:0] r_clr;

    // Item being worked on.
    lvs_pkg::t_action          r_act;
    logic [lvs_pkg::SLOT_W-1:0] r_slot;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_tag_ok;
    logic                      r_refs_nz;

    // Walk and splice registers.
    logic [IDX_W-1:0] r_cur;
    logic [IDX_W-1:0] r_last;
    logic [CNT_W-1:0] r_steps;
    logic             r_strict;
    logic [IDX_W-1:0] r_p;
    logic [IDX_W-1:0] r_q;

    // Result beat.
    logic                       r_valid;
    logic                       r_found;
    logic [lvs_pkg::SLOT_W-1:0] r_victim;
    logic                       r_err;

    // Memory ports.
    logic             w_nxt_we;
    logic [IDX_W-1:0] w_nxt_waddr;
    logic [IDX_W-1:0] w_nxt_wdata;
    logic [IDX_W-1:0] w_nxt_rdata;
    logic             w_prv_we;
    logic [IDX_W-1:0] w_prv_waddr;
    logic [IDX_W-1:0] w_prv_wdata;
    logic [IDX_W-1:0] w_prv_rdata;
    logic             w_flg_we;
    logic [IDX_W-1:0] w_flg_waddr;
    logic [1:0]       w_flg_wdata;
    logic [1:0]       w_flg_rdata;
    logic [IDX_W-1:0] w_raddr;

    logic [PAD_W-1:0] w_slot_pad;
    logic [PAD_W-1:0] w_cur_pad;
    logic [IDX_W-1:0] w_init_next;
    logic [IDX_W-1:0] w_init_prev;

    assign w_slot_pad  = PAD_W'(i_slot_index);
    assign w_cur_pad   = PAD_W'(r_cur);
    assign w_init_next = o_stat.clr_last ? '0 : r_clr + 1'b1;
    assign w_init_prev = (r_clr == '0) ? IDX_W'(ENTRIES - 1) : r_clr - 1'b1;

    // Status toward the controller.
    always_comb begin
        o_stat.action    = r_act;
        o_stat.in_range  = (32'(r_slot) < 32'(ENTRIES));
        o_stat.is_head   = (r_idx == r_head);
        o_stat.is_tail   = (r_idx == r_tail);
        o_stat.pinned    = w_flg_rdata[0] && (r_strict || w_flg_rdata[1]);
        o_stat.walk_last = (r_steps == CNT_W'(ENTRIES - 1));
        o_stat.clr_last  = (r_clr == IDX_W'(ENTRIES - 1));
    end

    // Shared read address for all three memories.
    always_comb begin
        case (i_cmd.rd_src)
            lvs_pkg::RD_HEAD: w_raddr = r_head;
            lvs_pkg::RD_NEXT: w_raddr = w_nxt_rdata;
            default:          w_raddr = r_idx;
        endcase
    end

    // Link writes: initial circle, unlink, append after tail, close to head.
    always_comb begin
        w_nxt_we    = 1'b1;
        w_prv_we    = 1'b1;
        w_nxt_waddr = r_idx;
        w_nxt_wdata = r_head;
        w_prv_waddr = r_head;
        w_prv_wdata = r_idx;
        case (i_cmd.link_wr)
            lvs_pkg::LW_INIT: begin
                w_nxt_waddr = r_clr;
                w_nxt_wdata = w_init_next;
                w_prv_waddr = r_clr;
                w_prv_wdata = w_init_prev;
            end
            lvs_pkg::LW_UNLINK: begin
                w_nxt_waddr = r_p;
                w_nxt_wdata = r_q;
                w_prv_waddr = r_q;
                w_prv_wdata = r_p;
            end
            lvs_pkg::LW_TAIL: begin
                w_nxt_waddr = r_tail;
                w_nxt_wdata = r_idx;
                w_prv_waddr = r_idx;
                w_prv_wdata = r_tail;
            end
            lvs_pkg::LW_HEAD: begin
                w_nxt_waddr = r_idx;
                w_nxt_wdata = r_head;
                w_prv_waddr = r_head;
                w_prv_wdata = r_idx;
            end
            default: begin
                w_nxt_we = 1'b0;
                w_prv_we = 1'b0;
            end
        endcase
    end

    // Flag writes: bit 1 is the tag valid bit, bit 0 says refs are nonzero.
    assign w_flg_we    = i_cmd.flag_init || i_cmd.flag_write;
    assign w_flg_waddr = i_cmd.flag_init ? r_clr : r_idx;
    assign w_flg_wdata = i_cmd.flag_init ? 2'b00 : {r_tag_ok, r_refs_nz};

    lvs_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_nxt_we),
        .i_waddr (w_nxt_waddr),
        .i_wdata (w_nxt_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_nxt_rdata)
    );

    lvs_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prv_we),
        .i_waddr (w_prv_waddr),
        .i_wdata (w_prv_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_prv_rdata)
    );

    lvs_ram #(.WIDTH(2), .DEPTH(ENTRIES)) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (w_flg_we),
        .i_waddr (w_flg_waddr),
        .i_wdata (w_flg_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_flg_rdata)
    );

    // Control state: head, tail, unused count, clear counter, result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= IDX_W'(ENTRIES - 1);
            r_unused <= CNT_W'(ENTRIES);
            r_clr    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_plain || i_cmd.alloc_hit || i_cmd.alloc_miss;
            if (i_cmd.clr_step && !o_stat.clr_last) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.touch_head) begin
                r_head <= w_nxt_rdata;
                r_tail <= r_idx;
            end
            if (i_cmd.link_wr == lvs_pkg::LW_HEAD) begin
                r_tail <= r_idx;
            end
            // A hit after some rotations moves the head onto the victim.
            if (i_cmd.alloc_hit) begin
                if (r_steps != '0) begin
                    r_head <= r_cur;
                    r_tail <= r_last;
                end
                if (!r_strict) begin
                    r_unused <= r_unused - 1'b1;
                end
            end
        end
    end

    // Item, walk and result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act     <= lvs_pkg::t_action'(i_action);
            r_slot    <= i_slot_index;
            r_idx     <= w_slot_pad[IDX_W-1:0];
            r_tag_ok  <= i_tag_valid;
            r_refs_nz <= (i_ref_count != '0);
        end
        if (i_cmd.alloc_start) begin
            r_cur    <= r_head;
            r_steps  <= '0;
            r_strict <= (r_unused == '0);
        end
        if (i_cmd.walk_step) begin
            r_last  <= r_cur;
            r_cur   <= w_nxt_rdata;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.touch_cap) begin
            r_p <= w_prv_rdata;
            r_q <= w_nxt_rdata;
        end
        if (i_cmd.emit_plain) begin
            r_found  <= 1'b0;
            r_victim <= r_slot;
            r_err    <= 1'b0;
        end
        if (i_cmd.alloc_hit) begin
            r_found  <= 1'b1;
            r_victim <= w_cur_pad[lvs_pkg::SLOT_W-1:0];
            r_err    <= 1'b0;
        end
        if (i_cmd.alloc_miss) begin
            r_found  <= 1'b0;
            r_victim <= '0;
            r_err    <= !r_strict;
        end
    end

    assign o_valid          = r_valid;
    assign o_found          = r_found;
    assign o_victim_slot    = r_victim;
    assign o_unstable_error = r_err;

endmodule

>>> design/lru_victim_select_with_pinning.sv
// LRU victim selector with reference pinning. A command beat is taken when
// i_start is high and o_busy is low; each command gives exactly one result
// beat, shown for one cycle with o_valid high, and the receiver cannot stall
// it. Write, touch of the tail or of an out-of-range slot, and the unused
// action answer straight from decode; a touch of the head is a plain
// rotation, and a general touch does one link read and three link writes.
// Allocate rotates past the pinned slots, examining at most ENTRIES slots
// when every slot is pinned: the walk reads one slot of the link memory per
// cycle. After reset the block is busy while it builds the initial order
// and clears the slot flags. The tag value is accepted but is never
// observable at the outputs, so it is not stored.
module lru_victim_select_with_pinning #(
    parameter int ENTRIES = lvs_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [1:0]                 i_action,
    input  logic [lvs_pkg::SLOT_W-1:0] i_slot_index,
    input  logic [lvs_pkg::TAG_W-1:0]  i_tag_value,
    input  logic                       i_tag_valid,
    input  logic [lvs_pkg::REFS_W-1:0] i_ref_count,
    output logic                       o_valid,
    output logic                       o_found,
    output logic [lvs_pkg::SLOT_W-1:0] o_victim_slot,
    output logic                       o_unstable_error
);

    lvs_pkg::t_cmd  w_cmd;
    lvs_pkg::t_stat w_stat;

    // Sequencer.
    lvs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    // Order memories, slot flags and result registers.
    lvs_datapath #(.ENTRIES(ENTRIES)) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_action         (i_action),
        .i_slot_index     (i_slot_index),
        .i_tag_valid      (i_tag_valid),
        .i_ref_count      (i_ref_count),
        .o_valid          (o_valid),
        .o_found          (o_found),
        .o_victim_slot    (o_victim_slot),
        .o_unstable_error (o_unstable_error)
    );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lvs_pkg::*;

    localparam int         NUM_SLOTS  = ENTRIES_DEF;
    localparam logic [6:0] NO_LINK    = 7'(NUM_SLOTS);
    localparam int         TAIL_WAIT  = NUM_SLOTS + 8;
    localparam int         DRAIN_WAIT = 4000;

    // Expected contents of one result beat.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] victim;
        logic              unstable;
    } t_outcome;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_start          = 1'b0;
    logic [1:0]        i_action         = 2'd0;
    logic [SLOT_W-1:0] i_slot_index     = '0;
    logic [TAG_W-1:0]  i_tag_value      = '0;
    logic              i_tag_valid      = 1'b0;
    logic [REFS_W-1:0] i_ref_count      = '0;
    logic              o_busy;
    logic              o_valid;
    logic              o_found;
    logic [SLOT_W-1:0] o_victim_slot;
    logic              o_unstable_error;

    // Shadow copy of the replacement list and the slot flags.
    logic [6:0]        lru_next [0:NUM_SLOTS];
    logic [6:0]        lru_prev [0:NUM_SLOTS];
    logic [6:0]        lru_first;
    logic [6:0]        mru_last;
    logic [6:0]        unused_left;
    logic [TAG_W-1:0]  shadow_tag  [0:NUM_SLOTS-1];
    logic              shadow_ok   [0:NUM_SLOTS-1];
    logic [REFS_W-1:0] shadow_refs [0:NUM_SLOTS-1];

    t_outcome pending_outcomes[$];
    int       mismatch_count = 0;
    int       beats_sent     = 0;
    int       idle_pct       = 25;

    lru_victim_select_with_pinning #(
        .ENTRIES(NUM_SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_action        (i_action),
        .i_slot_index    (i_slot_index),
        .i_tag_value     (i_tag_value),
        .i_tag_valid     (i_tag_valid),
        .i_ref_count     (i_ref_count),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_victim_slot   (o_victim_slot),
        .o_unstable_error(o_unstable_error)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Restore the power-up order 0..N-1 and clear every slot.
    function automatic void lru_order_reset();
        for (int i = 0; i <= NUM_SLOTS; i++) begin
            lru_next[i] = NO_LINK;
            lru_prev[i] = NO_LINK;
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            lru_next[i] = (i + 1 < NUM_SLOTS) ? 7'(i + 1) : NO_LINK;
            lru_prev[i] = (i > 0) ? 7'(i - 1) : NO_LINK;
            shadow_tag[i]  = '0;
            shadow_ok[i]   = 1'b0;
            shadow_refs[i] = '0;
        end
        lru_first   = 7'd0;
        mru_last    = 7'(NUM_SLOTS - 1);
        unused_left = 7'(NUM_SLOTS);
    endfunction

    // Unlink a slot and append it at the most recent end.
    function automatic void move_to_mru(logic [6:0] n);
        logic [6:0] p;
        logic [6:0] q;
        if (n < NUM_SLOTS && lru_first != mru_last && n != mru_last) begin
            if (n == lru_first) begin
                lru_first = lru_next[n];
                lru_prev[lru_first] = NO_LINK;
            end else begin
                p = lru_prev[n];
                q = lru_next[n];
                lru_next[p] = q;
                lru_prev[q] = p;
            end
            lru_next[mru_last] = n;
            lru_prev[n] = mru_last;
            lru_next[n] = NO_LINK;
            mru_last = n;
        end
    endfunction

    // Once the unused slots are gone any reference pins; before that the tag must be valid too.
    function automatic logic slot_pinned(logic [6:0] s, logic refs_only);
        if (s >= NUM_SLOTS) return 1'b0;
        if (refs_only) return shadow_refs[s] != 0;
        return shadow_refs[s] != 0 && shadow_ok[s];
    endfunction

    // Apply one command beat to the shadow state and give the result it causes.
    function automatic t_outcome predict_outcome(t_action act, logic [SLOT_W-1:0] idx,
                                                 logic [TAG_W-1:0] tag, logic ok,
                                                 logic [REFS_W-1:0] refs);
        t_outcome   res;
        logic       refs_only;
        logic [6:0] start_slot;
        int         steps;
        logic       gave_up;
        res = '{found: 1'b0, victim: idx, unstable: 1'b0};
        case (act)
            ACT_TOUCH: begin
                move_to_mru({1'b0, idx});
            end
            ACT_WRITE: begin
                shadow_tag[idx]  = tag;
                shadow_ok[idx]   = ok;
                shadow_refs[idx] = refs;
            end
            ACT_ALLOC: begin
                refs_only  = (unused_left == 0);
                start_slot = lru_first;
                steps      = 0;
                gave_up    = 1'b0;
                res.victim = '0;
                // Rotate pinned slots to the tail; a full circle means nothing is free.
                while (!gave_up && slot_pinned(lru_first, refs_only)) begin
                    move_to_mru(lru_first);
                    steps++;
                    if (lru_first == start_slot || steps >= NUM_SLOTS) gave_up = 1'b1;
                end
                if (!gave_up) begin
                    res.found  = 1'b1;
                    res.victim = lru_first[SLOT_W-1:0];
                    if (!refs_only) unused_left--;
                end else if (!refs_only) begin
                    res.unstable = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Drive one command beat, hold it until accepted, then record its outcome.
    task automatic send_beat(input t_action act, input logic [SLOT_W-1:0] idx,
                             input logic [TAG_W-1:0] tag, input logic ok,
                             input logic [REFS_W-1:0] refs);
        i_start      <= 1'b1;
        i_action     <= act;
        i_slot_index <= idx;
        i_tag_value  <= tag;
        i_tag_valid  <= ok;
        i_ref_count  <= refs;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        pending_outcomes.push_back(predict_outcome(act, idx, tag, ok, refs));
        beats_sent++;
    endtask

    // Random idle gap for the sender, taken with the current odds.
    task automatic sender_gap();
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        int cycles;
        cycles = 0;
        i_start <= 1'b0;
        while (pending_outcomes.size() != 0 && cycles < DRAIN_WAIT) begin
            @(posedge i_clk);
            cycles++;
        end
    endtask

    function automatic logic [TAG_W-1:0] random_tag();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [REFS_W-1:0] random_refs();
        case ($urandom_range(0, 5))
            0, 1, 2: return '0;
            3:       return '1;
            default: return REFS_W'($urandom_range(1, 255));
        endcase
    endfunction

    // Extremes of every field, every action, and touches at both list ends.
    task automatic test_directed();
        send_beat(ACT_TOUCH, 6'd63, '0, 1'b0, '0);
        send_beat(ACT_TOUCH, 6'd0, '1, 1'b1, '1);
        send_beat(ACT_TOUCH, 6'd32, 32'h5555_AAAA, 1'b0, 8'h55);
        send_beat(ACT_NONE, 6'd63, '1, 1'b1, '1);
        send_beat(ACT_NONE, 6'd0, '0, 1'b0, '0);
        send_beat(ACT_ALLOC, 6'd17, '0, 1'b0, '0);
        send_beat(ACT_WRITE, 6'd0, '0, 1'b0, '0);
        send_beat(ACT_WRITE, 6'd1, '1, 1'b1, '1);
        send_beat(ACT_WRITE, 6'd63, 32'hAAAA_5555, 1'b1, 8'd1);
        send_beat(ACT_WRITE, 6'd2, 32'h1234_5678, 1'b0, 8'hFF);
        send_beat(ACT_TOUCH, 6'd1, '0, 1'b0, '0);
        send_beat(ACT_ALLOC, 6'd0, '0, 1'b0, '0);
        send_beat(ACT_TOUCH, 6'd2, '0, 1'b0, '0);
        send_beat(ACT_TOUCH, 6'd63, '0, 1'b0, '0);
        send_beat(ACT_ALLOC, 6'd63, '1, 1'b1, '1);
        send_beat(ACT_WRITE, 6'd1, '0, 1'b1, '0);
        send_beat(ACT_ALLOC, 6'd1, '0, 1'b0, '0);
        send_beat(ACT_TOUCH, 6'd1, '0, 1'b0, '0);
        send_beat(ACT_TOUCH, 6'd1, '0, 1'b0, '0);
        send_beat(ACT_ALLOC, 6'd0, '0, 1'b0, '0);
    endtask

    // Pin every slot, starting at a random offset.
    task automatic pin_every_slot(input logic need_valid);
        int base;
        logic [SLOT_W-1:0] s;
        base = $urandom_range(0, NUM_SLOTS - 1);
        for (int k = 0; k < NUM_SLOTS; k++) begin
            s = SLOT_W'((base + k) % NUM_SLOTS);
            send_beat(ACT_WRITE, s, random_tag(), need_valid ? 1'b1 : 1'($urandom_range(0, 1)),
                      REFS_W'($urandom_range(1, 255)));
            sender_gap();
        end
    endtask

    // Every slot pinned while unused slots remain: allocate reports instability.
    task automatic test_unstable_circle();
        pin_every_slot(1'b1);
        send_beat(ACT_ALLOC, SLOT_W'($urandom), random_tag(), 1'b0, '0);
        sender_gap();
        send_beat(ACT_TOUCH, SLOT_W'($urandom), '0, 1'b0, '0);
        send_beat(ACT_ALLOC, SLOT_W'($urandom), '0, 1'b0, '0);
        // Dropping the valid bit of one slot unpins it.
        send_beat(ACT_WRITE, SLOT_W'($urandom), random_tag(), 1'b0, '1);
        send_beat(ACT_ALLOC, '0, '0, 1'b0, '0);
        sender_gap();
        send_beat(ACT_WRITE, SLOT_W'($urandom), random_tag(), 1'b1, '0);
        send_beat(ACT_ALLOC, '0, '0, 1'b0, '0);
    endtask

    // Mixed traffic with random content; the odds of each action are fixed per call.
    task automatic test_random_mix(input int count, input logic allow_idle);
        int pick;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                idle_pct = allow_idle ? $urandom_range(0, 3) * 15 : 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_beat(ACT_TOUCH, SLOT_W'($urandom), random_tag(), 1'($urandom),
                          REFS_W'($urandom));
            end else if (pick < 60) begin
                send_beat(ACT_ALLOC, SLOT_W'($urandom), random_tag(), 1'($urandom),
                          REFS_W'($urandom));
            end else if (pick < 95) begin
                send_beat(ACT_WRITE, SLOT_W'($urandom), random_tag(), 1'($urandom),
                          random_refs());
            end else begin
                send_beat(ACT_NONE, SLOT_W'($urandom), random_tag(), 1'($urandom),
                          REFS_W'($urandom));
            end
            sender_gap();
        end
    endtask

    // Use up the never-used slots so the stricter pin rule takes over.
    task automatic test_drain_unused();
        int guard;
        // Clear valid bits first; nothing is pinned under the loose rule then.
        for (int s = 0; s < NUM_SLOTS; s++) begin
            send_beat(ACT_WRITE, SLOT_W'(s), random_tag(), 1'b0, REFS_W'($urandom));
            sender_gap();
        end
        guard = 0;
        while (unused_left != 0 && guard < 1000) begin
            case ($urandom_range(0, 5))
                0:       send_beat(ACT_TOUCH, SLOT_W'($urandom), '0, 1'b0, '0);
                1:       send_beat(ACT_WRITE, SLOT_W'($urandom), random_tag(), 1'b0,
                                   REFS_W'($urandom));
                default: send_beat(ACT_ALLOC, SLOT_W'($urandom), '0, 1'b0, '0);
            endcase
            sender_gap();
            guard++;
        end
    endtask

    // Every slot referenced after the unused slots are gone: allocate finds nothing.
    task automatic test_no_slot();
        pin_every_slot(1'b0);
        send_beat(ACT_ALLOC, SLOT_W'($urandom), '0, 1'b0, '0);
        send_beat(ACT_TOUCH, SLOT_W'($urandom), '0, 1'b0, '0);
        sender_gap();
        send_beat(ACT_ALLOC, SLOT_W'($urandom), '0, 1'b1, '1);
        send_beat(ACT_WRITE, SLOT_W'($urandom), random_tag(), 1'($urandom), '0);
        send_beat(ACT_ALLOC, '0, '0, 1'b0, '0);
        send_beat(ACT_ALLOC, '0, '0, 1'b0, '0);
    endtask

    // Compare each result beat with the oldest outstanding outcome.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result beat with no command outstanding");
            end else begin
                want = pending_outcomes.pop_front();
                if (o_found !== want.found)
                    report_mismatch($sformatf("found %b, want %b", o_found, want.found));
                if (o_victim_slot !== want.victim)
                    report_mismatch($sformatf("victim_slot %0d, want %0d",
                                              o_victim_slot, want.victim));
                if (o_unstable_error !== want.unstable)
                    report_mismatch($sformatf("unstable_error %b, want %b",
                                              o_unstable_error, want.unstable));
            end
        end
    end

    initial begin
        #1000000;
        $display("lru_victim_select_with_pinning: mismatch");
        $finish;
    end

    initial begin
        lru_order_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_unstable_circle();
        test_random_mix(350, 1'b1);
        // Let everything settle before starting the drain.
        wait_all_results();
        test_drain_unused();
        test_no_slot();
        test_random_mix(250, 1'b1);
        test_random_mix(150, 1'b0);

        // Wait out the last results, then a full walk more for stray beats.
        wait_all_results();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pending_outcomes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
        if (mismatch_count == 0) begin
            $display("lru_victim_select_with_pinning: match");
        end else begin
            $display("lru_victim_select_with_pinning: mismatch");
        end
        $finish;
    end

endmodule
